// File: design/sorted_array_insert_delete_assert.svh
// ---------------------------------------------------------------------------
// sorted array assertion macros
// shared property forms for the checker, clocked on clk, reset by rst_n
// ---------------------------------------------------------------------------
`ifndef SORTED_ARRAY_INSERT_DELETE_ASSERT_SVH
`define SORTED_ARRAY_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define SAI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sai_pkg.sv
// ---------------------------------------------------------------------------
// sai_pkg
// shared types and constants of the sorted array block
// ---------------------------------------------------------------------------
`default_nettype none

package sai_pkg;

    // default number of entries
    localparam int DEFAULT_CAPACITY = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    // command word
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } in_word_t;

    // response word
    typedef struct packed {
        logic       success;
        logic [5:0] position;
        logic [5:0] count_after;
    } out_word_t;

    // update request from the controller to the cell row
    typedef struct packed {
        logic ins;
        logic del;
    } apply_t;

    // per-cell load select
    typedef struct packed {
        logic take_left;
        logic take_right;
        logic take_new;
    } cell_sel_t;

endpackage

`default_nettype wire

// File: design/sorted_array_insert_delete.sv
// ---------------------------------------------------------------------------
// sorted_array_insert_delete
// ascending list of signed 32-bit values with insert, delete and find
// ---------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+-----------------------------------
//  cmd     | cmd_valid / cmd_stall | cmd, value
//  rsp     | rsp_valid / rsp_stall | success, position, count_after
//
//  an accepted command passes the compare state, the search and the done state
//  to the response load; the search makes at most $clog2(CAPACITY + 1) probes,
//  one probe per cycle against the registered compare flags of the cell row
//  a new command is taken while the previous response waits; a finished
//  command holds until the response register is free
//  reset empties the list; the entry values themselves are not cleared
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_array_insert_delete #(
    parameter int CAPACITY = sai_pkg::DEFAULT_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sai_pkg::in_word_t  cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sai_pkg::out_word_t rsp_word
);
    import sai_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] key;
    apply_t             apply;
    logic [CW-1:0]      pos;
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] gt_vec;
    logic signed [31:0] cell_data [CAPACITY];

    // controller
    sai_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .lt_vec    (lt_vec),
        .gt_vec    (gt_vec),
        .key       (key),
        .apply     (apply),
        .pos       (pos)
    );

    // row of cells, shifting up on insert and down on delete
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_sel_t          sel;
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        assign sel.take_new   = apply.ins && (CW'(i) == pos);
        assign sel.take_left  = apply.ins && (CW'(i) > pos);
        assign sel.take_right = apply.del && (CW'(i) >= pos);

        if (i == 0)
        begin : g_first
            assign left_data = cell_data[i];
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        sai_cell u_cell (
            .clk        (clk),
            .sel        (sel),
            .key        (key),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .lt         (lt_vec[i]),
            .gt         (gt_vec[i])
        );
    end

endmodule

`default_nettype wire

// File: design/sai_cell.sv
// ---------------------------------------------------------------------------
// sai_cell
// one entry of the sorted row: holds a value, compares it against the key
// and loads from a neighbor or the key when the row shifts
// ---------------------------------------------------------------------------
`default_nettype none

module sai_cell (
    input  logic               clk,
    input  sai_pkg::cell_sel_t sel,
    input  logic signed [31:0] key,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    output logic signed [31:0] data,
    output logic               lt,
    output logic               gt
);
    import sai_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               lt_reg;
    logic               gt_reg;

    // next entry value
    always_comb
    begin
        if (sel.take_new)
        begin
            data_next = key;
        end
        else if (sel.take_left)
        begin
            data_next = left_data;
        end
        else if (sel.take_right)
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // entry and compare flags
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        lt_reg   <= ($signed(key) < $signed(data_reg));
        gt_reg   <= ($signed(key) > $signed(data_reg));
    end

    assign data = data_reg;
    assign lt   = lt_reg;
    assign gt   = gt_reg;

endmodule

`default_nettype wire

// File: design/sai_ctrl.sv
// ---------------------------------------------------------------------------
// sai_ctrl
// command handshake, binary search over the cell flags, entry count and
// response register
// ---------------------------------------------------------------------------
`default_nettype none

module sai_ctrl #(
    parameter int CAPACITY = sai_pkg::DEFAULT_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  sai_pkg::in_word_t  cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sai_pkg::out_word_t rsp_word,
    input  logic [CAPACITY-1:0] lt_vec,
    input  logic [CAPACITY-1:0] gt_vec,
    output logic signed [31:0] key,
    output sai_pkg::apply_t    apply,
    output logic [CW-1:0]      pos
);
    import sai_pkg::*;

    localparam int IDXW = $clog2(CAPACITY);
    localparam int PW   = (CW > 6) ? CW : 6;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [1:0]         op_reg;
    logic [1:0]         op_next;
    logic signed [31:0] key_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      lo_next;
    logic [CW-1:0]      hi1_reg;
    logic [CW-1:0]      hi1_next;
    logic               hit_reg;
    logic               hit_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    out_word_t          rsp_word_reg;
    out_word_t          rsp_word_next;

    logic               accept;
    logic               finish;
    logic               not_full;
    logic               success;
    logic [CW-1:0]      mid;
    logic [IDXW-1:0]    mid_idx;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      count_ext;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign finish    = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign not_full  = (count_reg < CW'(CAPACITY));

    // probe point halfway through the half-open range [lo, hi1)
    assign mid     = lo_reg + ((hi1_reg - lo_reg - CW'(1)) >> 1);
    assign mid_idx = mid[IDXW-1:0];

    // outcome of the finished command
    always_comb
    begin
        case (op_reg)
            CMD_INSERT: success = not_full;
            CMD_DELETE: success = hit_reg;
            CMD_FIND:   success = hit_reg;
            default:    success = 1'b0;
        endcase
    end

    assign apply.ins = finish && (op_reg == CMD_INSERT) && not_full;
    assign apply.del = finish && (op_reg == CMD_DELETE) && hit_reg;

    // sequencer and search step
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        lo_next    = lo_reg;
        hi1_next   = hi1_reg;
        hit_next   = hit_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                    op_next    = cmd_word.cmd;
                    lo_next    = '0;
                    hit_next   = 1'b0;
                    hi1_next   = (cmd_word.cmd == CMD_INSERT || cmd_word.cmd == CMD_DELETE
                                  || cmd_word.cmd == CMD_FIND) ? count_reg : '0;
                end
            end
            ST_CMP:
            begin
                state_next = ST_SRCH;
            end
            ST_SRCH:
            begin
                if (hit_reg || !(lo_reg < hi1_reg))
                begin
                    state_next = ST_DONE;
                end
                else if (lt_vec[mid_idx])
                begin
                    hi1_next = mid;
                end
                else if (gt_vec[mid_idx])
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    lo_next  = mid;
                    hit_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                    if (apply.ins)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else if (apply.del)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response register
    assign pos_ext   = PW'(lo_reg);
    assign count_ext = PW'(count_next);

    always_comb
    begin
        rsp_word_next = rsp_word_reg;
        if (finish)
        begin
            rsp_valid_next            = 1'b1;
            rsp_word_next.success     = success;
            rsp_word_next.position    = pos_ext[5:0];
            rsp_word_next.count_after = count_ext[5:0];
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= CMD_INSERT;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi1_reg       <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi1_reg       <= hi1_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= cmd_word.value;
        end
        rsp_word_reg <= rsp_word_next;
    end

    assign key       = key_reg;
    assign pos       = lo_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

// File: design/sai_check.sv
// ---------------------------------------------------------------------------
// sai_check
// port-level checks of the sorted array block, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_array_insert_delete_assert.svh"

module sai_check (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input sai_pkg::out_word_t rsp_word
);
    import sai_pkg::*;

    logic       cmd_fire;
    logic       rsp_fire;
    logic [5:0] last_count_reg;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign cmd_fire = cmd_valid && !cmd_stall;
    assign rsp_fire = rsp_valid && !rsp_stall;

    // commands taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_fire && !cmd_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    // last delivered count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (rsp_fire)
            begin
                last_count_reg <= rsp_word.count_after;
            end
        end
    end

    `SAI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(rsp_word), "response word changed while stalled")

    `SAI_ASSERT_SAME(a_rsp_owed, rsp_valid, pending_reg != 2'd0,
        "response word without a pending command")

    `SAI_ASSERT_SAME(a_count_step, rsp_fire,
        rsp_word.count_after == last_count_reg
        || rsp_word.count_after == last_count_reg + 6'd1
        || rsp_word.count_after == last_count_reg - 6'd1,
        "entry count moved by more than one")

    `SAI_ASSERT_SAME(a_fail_keeps, rsp_fire && !rsp_word.success,
        rsp_word.count_after == last_count_reg, "failed command changed the count")

endmodule

bind sorted_array_insert_delete sai_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for sorted_array_insert_delete
// sends insert, delete, find and unused command words, predicts each response
// from a software copy of the sorted list, and compares every response field
// in order; both sides idle at random, and the response side holds off once
// for long enough that the command side backs up
// ---------------------------------------------------------------------------

// software copy of the sorted list plus the queue of predicted responses
class sorted_list_model #(int DEPTH = 32);
    logic signed [31:0] entries [DEPTH];
    int                 count;
    int                 errors;
    sai_pkg::out_word_t expected_responses [$];

    function new();
        count  = 0;
        errors = 0;
    endfunction

    // binary search over valid entries: match index, else insertion point
    function int probe(logic signed [31:0] v, output bit hit);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = count - 1;
        hit = 1'b0;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (v < entries[mid])
            begin
                hi = mid - 1;
            end
            else if (v > entries[mid])
            begin
                lo = mid + 1;
            end
            else
            begin
                hit = 1'b1;
                return mid;
            end
        end
        return lo;
    endfunction

    // apply one accepted command word and queue the response it must cause
    function void note_command(sai_pkg::in_word_t w);
        sai_pkg::out_word_t rsp;
        bit                 hit;
        int                 pos;
        rsp = '0;
        hit = 1'b0;
        pos = 0;
        case (w.cmd)
            sai_pkg::CMD_INSERT:
            begin
                pos = probe(w.value, hit);
                // a full list refuses the insert but still reports the search
                if (count < DEPTH)
                begin
                    for (int i = count; i > pos; i--)
                        entries[i] = entries[i - 1];
                    entries[pos] = w.value;
                    count++;
                    rsp.success = 1'b1;
                end
            end
            sai_pkg::CMD_DELETE:
            begin
                // empty list reports position zero without searching
                if (count != 0)
                begin
                    pos = probe(w.value, hit);
                    if (hit)
                    begin
                        for (int i = pos; i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        count--;
                        rsp.success = 1'b1;
                    end
                end
            end
            sai_pkg::CMD_FIND:
            begin
                pos = probe(w.value, hit);
                rsp.success = hit;
            end
            default:
            begin
                // unused command leaves the list alone
            end
        endcase
        rsp.position    = 6'(pos);
        rsp.count_after = 6'(count);
        expected_responses.push_back(rsp);
    endfunction

    function void compare_field(string name, int want, logic [5:0] got);
        if (got !== 6'(want))
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // compare one accepted response word against the oldest prediction
    function void check_response(sai_pkg::out_word_t got);
        sai_pkg::out_word_t want;
        if (expected_responses.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
        end
        want = expected_responses.pop_front();
        compare_field("success", want.success, 6'(got.success));
        compare_field("position", want.position, got.position);
        compare_field("count_after", want.count_after, got.count_after);
    endfunction

    function int pending();
        return expected_responses.size();
    endfunction
endclass

module testbench;

    localparam int         CAP          = sai_pkg::DEFAULT_CAPACITY;
    localparam int         RANDOM_WORDS = 730;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         HOLD_AT      = 300;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    sai_pkg::in_word_t  cmd_word;
    logic               rsp_valid;
    logic               rsp_stall;
    sai_pkg::out_word_t rsp_word;

    sorted_list_model #(CAP) model;
    int                      cmd_sent;
    int                      rsp_seen;

    sorted_array_insert_delete #(
        .CAPACITY (CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // windows of words with no idling on either side
    function automatic bit no_idle(int n);
        return (n % 120) >= 80;
    endfunction

    // operand mix: stored entries for hits, a small band for duplicates,
    // the signed extremes, and full-range values
    function automatic logic signed [31:0] pick_value(int hit_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < hit_pct && model.count > 0)
            return model.entries[$urandom_range(0, model.count - 1)];
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 32'($urandom_range(0, 16)) - 32'sd8;
        if (sel < 7)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h8000_0001;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h7FFF_FFFE;
                4:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // offer one command word after a random gap and hold it until taken
    task automatic send(input logic [1:0] c, input logic signed [31:0] v);
        int                gap;
        sai_pkg::in_word_t w;
        w.cmd   = c;
        w.value = v;
        gap = no_idle(cmd_sent) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        model.note_command(w);
        cmd_sent++;
    endtask

    // command side
    initial
    begin
        bit         filling;
        int         sel;
        logic [1:0] c;
        model     = new();
        cmd_sent  = 0;
        filling   = 1'b1;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_word  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        send(sai_pkg::CMD_FIND, 32'sd0);
        send(sai_pkg::CMD_DELETE, 32'sd5);
        // extremes, duplicates and ordering
        send(sai_pkg::CMD_INSERT, 32'sd0);
        send(sai_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        send(sai_pkg::CMD_INSERT, 32'h8000_0000);
        send(sai_pkg::CMD_INSERT, -32'sd1);
        send(sai_pkg::CMD_INSERT, 32'sd0);
        send(sai_pkg::CMD_INSERT, 32'sd1);
        // hits at both ends and in the middle, misses in between
        send(sai_pkg::CMD_FIND, 32'sd0);
        send(sai_pkg::CMD_FIND, 32'h8000_0000);
        send(sai_pkg::CMD_FIND, 32'h7FFF_FFFF);
        send(sai_pkg::CMD_FIND, 32'sd7);
        send(sai_pkg::CMD_FIND, -32'sd5);
        send(CMD_UNUSED, 32'sd12345);
        // absent delete, then removal from both ends and of duplicates
        send(sai_pkg::CMD_DELETE, 32'sd3);
        send(sai_pkg::CMD_DELETE, 32'h7FFF_FFFF);
        send(sai_pkg::CMD_DELETE, 32'h8000_0000);
        send(sai_pkg::CMD_DELETE, 32'sd0);
        send(sai_pkg::CMD_DELETE, 32'sd0);
        send(sai_pkg::CMD_DELETE, 32'sd0);
        // absent value above every entry
        send(sai_pkg::CMD_DELETE, 32'h7FFF_FFFF);
        send(CMD_UNUSED, 32'hFFFF_FFFF);

        // random part: fill up to full, stay a while, drain down to empty
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (filling && model.count == CAP && $urandom_range(0, 5) == 0)
                filling = 1'b0;
            else if (!filling && model.count == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 3)
                c = CMD_UNUSED;
            else if (sel < 17)
                c = sai_pkg::CMD_FIND;
            else if (sel < 77)
                c = filling ? sai_pkg::CMD_INSERT : sai_pkg::CMD_DELETE;
            else
                c = filling ? sai_pkg::CMD_DELETE : sai_pkg::CMD_INSERT;
            if (c == sai_pkg::CMD_DELETE && !filling)
                send(c, pick_value(85));
            else
                send(c, pick_value(45));
        end
        cmd_valid <= 1'b0;

        // wait out the remaining responses, then a margin for strays
        while (model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // response side, with one long hold-off to back up the block
    initial
    begin
        int gap;
        rsp_seen  = 0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rsp_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            else if (no_idle(rsp_seen))
                gap = 0;
            else
                gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            model.check_response(rsp_word);
            rsp_seen++;
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("testbench: errors");
        $finish;
    end

endmodule

// File: sorted_array_insert_delete.f
+incdir+design
design/sai_pkg.sv
design/sai_cell.sv
design/sai_ctrl.sv
design/sorted_array_insert_delete.sv
design/sai_check.sv
tb/sv/testbench.sv
